// File: src/assert_macros.svh
// Assertion macros used by the checker file lli_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define LLI_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LLI_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/lli_pkg.sv
// ----------------------------------------------------------------------------
// lli_pkg
// Widths, types and helper functions of the 3D line intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lli_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int DIFF_W  = COORD_W + 1;     // extents and offsets
  localparam int DET_W   = 2 * DIFF_W;      // determinant and numerators
  localparam int SPLIT_W = DIFF_W;          // low slice of a numerator
  localparam int PROD_W  = DET_W + DIFF_W;  // numerator times extent
  localparam int QUO_W   = PROD_W - 2;      // dividend and quotient magnitude
  localparam int DIV_W   = DET_W - 1;       // divisor magnitude
  localparam int ACC_W   = DIV_W + QUO_W;   // remainder and shifting dividend
  localparam int SUM_W   = QUO_W + 2;       // start point plus signed quotient
  localparam int LANES   = 4;               // x, y, z on line A, check axis on B
  localparam int LANE_B  = 3;

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DET_W-1:0]   det_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t a0x;
    coord_t a0y;
    coord_t a0z;
    coord_t b0w;
    axis_t  w;
  } pts_t;

  typedef struct packed {
    pts_t             pts;
    logic             dz;
    logic [LANES-1:0] neg;
  } side_t;

  typedef struct packed {
    logic [LANES-1:0][QUO_W-1:0] num;
    logic [DIV_W-1:0]            den;
    side_t                       side;
  } div_word_t;

  // One restoring division step: shift in the next dividend bit, subtract
  // the divisor if it fits, shift the quotient bit in at the bottom.
  function automatic logic [ACC_W-1:0] div_step(input logic [ACC_W-1:0] acc,
                                                input logic [DIV_W-1:0] d);
    logic [DIV_W:0]   t;
    logic [DIV_W+1:0] diff;
    logic [DIV_W-1:0] rem;
    logic             qbit;
    t    = acc[ACC_W-1:QUO_W-1];
    diff = {1'b0, t} - {2'b00, d};
    qbit = !diff[DIV_W+1];
    rem  = qbit ? diff[DIV_W-1:0] : t[DIV_W-1:0];
    return {rem, acc[QUO_W-2:0], qbit};
  endfunction

  // Integer part of a signed Q83.16 value (sum_t), rounded toward zero.
  function automatic sum_t int_part(input sum_t x);
    sum_t bias;
    bias = x[SUM_W-1] ? sum_t'((1 << FRAC_W) - 1) : '0;
    return (x + bias) >>> FRAC_W;
  endfunction

  function automatic coord_t sat_coord(input sum_t x);
    if (x[SUM_W-1:COORD_W-1] == '0 || x[SUM_W-1:COORD_W-1] == '1) begin
      return x[COORD_W-1:0];
    end else if (x[SUM_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

endpackage

`default_nettype wire

// File: src/lli_line_if.sv
// ----------------------------------------------------------------------------
// lli_line_if
// Input channel: one pair of 3D lines, two points each, Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

interface lli_line_if import lli_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t a_start_x;
  coord_t a_start_y;
  coord_t a_start_z;
  coord_t a_end_x;
  coord_t a_end_y;
  coord_t a_end_z;
  coord_t b_start_x;
  coord_t b_start_y;
  coord_t b_start_z;
  coord_t b_end_x;
  coord_t b_end_y;
  coord_t b_end_z;

  modport source (
    output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
           b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
    input  ready
  );

  modport sink (
    input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
           b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
    output ready
  );
endinterface

`default_nettype wire

// File: src/lli_hit_if.sv
// ----------------------------------------------------------------------------
// lli_hit_if
// Output channel: intersection point and hit flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lli_hit_if import lli_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t hit_x;
  coord_t hit_y;
  coord_t hit_z;
  logic   hit_valid;

  modport source (output valid, hit_x, hit_y, hit_z, hit_valid, input ready);
  modport sink   (input valid, hit_x, hit_y, hit_z, hit_valid, output ready);
endinterface

`default_nettype wire

// File: src/lli_front.sv
// ----------------------------------------------------------------------------
// lli_front
// Six-stage front end: extents, plane choice, determinant and numerators,
// split wide products, and sign/magnitude split for the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_front import lli_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  adv,
  lli_line_if.sink   lines,
  output logic       div_valid,
  output div_word_t  div_word
);

  typedef struct packed {
    diff_t d1x;
    diff_t d1y;
    diff_t d1z;
    diff_t d2w;
    pts_t  pts;
  } carry_t;

  typedef struct packed {
    diff_t  du1, dv1, du2, dv2, eu, ev;
    carry_t c;
  } s1_t;

  typedef struct packed {
    det_t   pda, pdb, p1a, p1b, p2a, p2b;
    carry_t c;
  } s2_t;

  typedef struct packed {
    det_t   den, n1, n2;
    carry_t c;
  } s3_t;

  typedef struct packed {
    logic [LANES-1:0][DET_W:0]   pl;
    logic [LANES-1:0][DET_W-1:0] ph;
    det_t                        den;
    pts_t                        pts;
  } s4_t;

  typedef struct packed {
    logic [LANES-1:0][PROD_W-1:0] prod;
    det_t                         den;
    pts_t                         pts;
  } s5_t;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  div_word_t div_next;
  logic [5:0] vld;

  coord_t as [3];
  coord_t ae [3];
  coord_t bs [3];
  coord_t be [3];
  diff_t  d1 [3];
  diff_t  d2 [3];
  diff_t  e  [3];
  axis_t  u, v, w;

  assign lines.ready = adv;

  assign as[0] = lines.a_start_x;
  assign as[1] = lines.a_start_y;
  assign as[2] = lines.a_start_z;
  assign ae[0] = lines.a_end_x;
  assign ae[1] = lines.a_end_y;
  assign ae[2] = lines.a_end_z;
  assign bs[0] = lines.b_start_x;
  assign bs[1] = lines.b_start_y;
  assign bs[2] = lines.b_start_z;
  assign be[0] = lines.b_end_x;
  assign be[1] = lines.b_end_y;
  assign be[2] = lines.b_end_z;

  // Stage 1: extents, offset, projection plane.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d1[k] = diff_t'(ae[k]) - diff_t'(as[k]);
      d2[k] = diff_t'(be[k]) - diff_t'(bs[k]);
      e[k]  = diff_t'(bs[k]) - diff_t'(as[k]);
    end
    if (d1[0] == '0 && d2[0] == '0) begin
      u = AXIS_Y;
      v = AXIS_Z;
      w = AXIS_X;
    end else if (d1[1] == '0 && d2[1] == '0) begin
      u = AXIS_Z;
      v = AXIS_X;
      w = AXIS_Y;
    end else begin
      u = AXIS_X;
      v = AXIS_Y;
      w = AXIS_Z;
    end
  end

  always_comb begin
    s1_next.du1       = d1[u];
    s1_next.dv1       = d1[v];
    s1_next.du2       = d2[u];
    s1_next.dv2       = d2[v];
    s1_next.eu        = e[u];
    s1_next.ev        = e[v];
    s1_next.c.d1x     = d1[0];
    s1_next.c.d1y     = d1[1];
    s1_next.c.d1z     = d1[2];
    s1_next.c.d2w     = d2[w];
    s1_next.c.pts.a0x = as[0];
    s1_next.c.pts.a0y = as[1];
    s1_next.c.pts.a0z = as[2];
    s1_next.c.pts.b0w = bs[w];
    s1_next.c.pts.w   = w;
  end

  // Stage 2: cross products.
  always_comb begin
    s2_next.pda = s1.du1 * s1.dv2;
    s2_next.pdb = s1.du2 * s1.dv1;
    s2_next.p1a = s1.eu * s1.dv2;
    s2_next.p1b = s1.ev * s1.du2;
    s2_next.p2a = s1.eu * s1.dv1;
    s2_next.p2b = s1.ev * s1.du1;
    s2_next.c   = s1.c;
  end

  // Stage 3: determinant and both numerators.
  always_comb begin
    s3_next.den = s2.pda - s2.pdb;
    s3_next.n1  = s2.p1a - s2.p1b;
    s3_next.n2  = s2.p2a - s2.p2b;
    s3_next.c   = s2.c;
  end

  // Stage 4: numerator times extent, as two partial products per lane.
  always_comb begin
    det_t                  nsel;
    diff_t                 dsel;
    logic signed [DET_W:0] plv;
    det_t                  phv;
    for (int l = 0; l < LANES; l++) begin
      nsel = (l == LANE_B) ? s3.n2 : s3.n1;
      case (l)
        0:       dsel = s3.c.d1x;
        1:       dsel = s3.c.d1y;
        2:       dsel = s3.c.d1z;
        default: dsel = s3.c.d2w;
      endcase
      plv = $signed({1'b0, nsel[SPLIT_W-1:0]}) * dsel;
      phv = $signed(nsel[DET_W-1:SPLIT_W]) * dsel;
      s4_next.pl[l] = plv;
      s4_next.ph[l] = phv;
    end
    s4_next.den = s3.den;
    s4_next.pts = s3.c.pts;
  end

  // Stage 5: recombine the partial products.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s5_next.prod[l] = (prod_t'($signed(s4.ph[l])) <<< SPLIT_W)
                        + prod_t'($signed(s4.pl[l]));
    end
    s5_next.den = s4.den;
    s5_next.pts = s4.pts;
  end

  // Stage 6: magnitudes and quotient signs for the divider.
  always_comb begin
    prod_t pv;
    prod_t mag;
    det_t  dabs;
    for (int l = 0; l < LANES; l++) begin
      pv  = $signed(s5.prod[l]);
      mag = pv[PROD_W-1] ? -pv : pv;
      div_next.num[l]      = mag[QUO_W-1:0];
      div_next.side.neg[l] = pv[PROD_W-1] ^ s5.den[DET_W-1];
    end
    dabs = s5.den[DET_W-1] ? -s5.den : s5.den;
    div_next.den       = dabs[DIV_W-1:0];
    div_next.side.dz   = (s5.den == '0);
    div_next.side.pts  = s5.pts;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1       <= s1_next;
      s2       <= s2_next;
      s3       <= s3_next;
      s4       <= s4_next;
      s5       <= s5_next;
      div_word <= div_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:0], lines.valid};
    end
  end

  assign div_valid = vld[5];

endmodule

`default_nettype wire

// File: src/lli_div.sv
// ----------------------------------------------------------------------------
// lli_div
// Pipelined restoring divider, one quotient bit per stage, four lanes that
// share one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_div import lli_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire div_word_t                    in_word,
  output logic                              out_valid,
  output logic [LANES-1:0][QUO_W-1:0]       quo,
  output side_t                             side
);

  logic [LANES-1:0][ACC_W-1:0] acc [QUO_W];
  logic [DIV_W-1:0]            den [QUO_W];
  side_t                       sd  [QUO_W];
  logic [QUO_W-1:0]            vld;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        acc[0][l] <= div_step({{DIV_W{1'b0}}, in_word.num[l]}, in_word.den);
      end
      den[0] <= in_word.den;
      sd[0]  <= in_word.side;
      for (int s = 1; s < QUO_W; s++) begin
        for (int l = 0; l < LANES; l++) begin
          acc[s][l] <= div_step(acc[s-1][l], den[s-1]);
        end
        den[s] <= den[s-1];
        sd[s]  <= sd[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[QUO_W-2:0], in_valid};
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = acc[QUO_W-1][l][QUO_W-1:0];
    end
  end

  assign side      = sd[QUO_W-1];
  assign out_valid = vld[QUO_W-1];

endmodule

`default_nettype wire

// File: src/lli_back.sv
// ----------------------------------------------------------------------------
// lli_back
// Two-stage back end: signed quotients added to the start points, check-axis
// compare, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_back import lli_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire logic [LANES-1:0][QUO_W-1:0]  quo,
  input  wire side_t                        side,
  lli_hit_if.source                         hit
);

  logic [LANES-1:0][SUM_W-1:0] c, c_next;
  axis_t                       w;
  logic                        dz;
  logic                        v1;

  sum_t   ca, cb;
  logic   hit_ok;
  coord_t hx, hy, hz;

  always_comb begin
    sum_t   qz;
    sum_t   qs;
    coord_t base;
    for (int l = 0; l < LANES; l++) begin
      qz = sum_t'({2'b00, quo[l]});
      qs = side.neg[l] ? -qz : qz;
      case (l)
        0:       base = side.pts.a0x;
        1:       base = side.pts.a0y;
        2:       base = side.pts.a0z;
        default: base = side.pts.b0w;
      endcase
      c_next[l] = sum_t'(base) + qs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c  <= c_next;
      w  <= side.pts.w;
      dz <= side.dz;
    end
  end

  // Check axis: integer parts of line A and line B must agree.
  always_comb begin
    case (w)
      AXIS_X:  ca = $signed(c[0]);
      AXIS_Y:  ca = $signed(c[1]);
      default: ca = $signed(c[2]);
    endcase
    cb     = $signed(c[LANE_B]);
    hit_ok = !dz && (int_part(ca) == int_part(cb));
    hx     = hit_ok ? sat_coord($signed(c[0])) : '0;
    hy     = hit_ok ? sat_coord($signed(c[1])) : '0;
    hz     = hit_ok ? sat_coord($signed(c[2])) : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit.hit_x     <= hx;
      hit.hit_y     <= hy;
      hit.hit_z     <= hz;
      hit.hit_valid <= hit_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      hit.valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      hit.valid <= v1;
    end
  end

endmodule

`default_nettype wire

// File: src/line3d_intersection.sv
// ----------------------------------------------------------------------------
// line3d_intersection
// Intersection point of two 3D lines given in signed Q16.16.
// ----------------------------------------------------------------------------
// Takes one line pair per clock while the consumer is not holding a result
// word, and returns one result word per pair, in order. The word shows on hit
// through 105 register stages: six front-end stages (extents, plane choice,
// determinant, split wide products, magnitudes), a 97-stage restoring divider
// that resolves one quotient bit per stage, and two back-end stages (start
// point add, check-axis compare, saturation, output register). When the result
// word is held by the consumer the whole pipeline freezes and lines.ready
// drops; nothing is lost or repeated. A zero determinant or a check-axis
// mismatch gives hit_valid low with all coordinates zero.
`default_nettype none

module line3d_intersection import lli_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  lli_line_if.sink   lines,
  lli_hit_if.source  hit
);

  logic      adv;
  logic      front_valid;
  div_word_t front_word;
  logic      div_valid;
  logic [LANES-1:0][QUO_W-1:0] div_quo;
  side_t     div_side;

  // Advance while the output register is empty or being taken.
  assign adv = !hit.valid || hit.ready;

  lli_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .lines     (lines),
    .div_valid (front_valid),
    .div_word  (front_word)
  );

  lli_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .in_word   (front_word),
    .out_valid (div_valid),
    .quo       (div_quo),
    .side      (div_side)
  );

  lli_back u_back (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (div_valid),
    .quo      (div_quo),
    .side     (div_side),
    .hit      (hit)
  );

endmodule

`default_nettype wire

// File: src/lli_checker.sv
// ----------------------------------------------------------------------------
// lli_checker
// Port-level checks on the line intersection block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lli_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        lines_ready,
  input wire logic        hit_ch_valid,
  input wire logic        hit_ch_ready,
  input wire logic        hit_flag,
  input wire logic [31:0] hit_x,
  input wire logic [31:0] hit_y,
  input wire logic [31:0] hit_z
);

  `LLI_ASSERT(a_hold_word, clk, rst, hit_ch_valid && !hit_ch_ready |=> hit_ch_valid && $stable(hit_x) && $stable(hit_y) && $stable(hit_z) && $stable(hit_flag), "result word changed while held")
  `LLI_ASSERT(a_miss_zero, clk, rst, hit_ch_valid && !hit_flag |-> hit_x == 0 && hit_y == 0 && hit_z == 0, "miss word carries a nonzero point")
  `LLI_ASSERT(a_ready_empty, clk, rst, !hit_ch_valid |-> lines_ready, "input stalled with empty output")
  `LLI_ASSERT(a_ready_stall, clk, rst, hit_ch_valid && !hit_ch_ready |-> !lines_ready, "input taken while output held")
  `LLI_ASSERT_RST(a_reset_empty, clk, rst |=> !hit_ch_valid, "output word valid after reset")

endmodule

bind line3d_intersection lli_checker u_lli_checker (
  .clk          (clk),
  .rst          (rst),
  .lines_ready  (lines.ready),
  .hit_ch_valid (hit.valid),
  .hit_ch_ready (hit.ready),
  .hit_flag     (hit.hit_valid),
  .hit_x        (hit.hit_x),
  .hit_y        (hit.hit_y),
  .hit_z        (hit.hit_z)
);

`default_nettype wire
